// ===== sv/periodic_transition_pattern_generator_unit_defines.svh =====
// Assertion macros for the pattern generator.
`ifndef PERIODIC_TRANSITION_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define PERIODIC_TRANSITION_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PTPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define PTPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ptpg_pkg.sv =====
`default_nettype none
package ptpg_pkg;

  localparam int unsigned TIME_BITS   = 48;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_BITS    = 4;
  localparam int unsigned CNT_BITS    = 5;
  localparam int unsigned STAT_BITS   = 3;
  localparam int unsigned DIV_CNT_BITS = $clog2(TIME_BITS);

  localparam logic [DATA_BITS-1:0] PERIOD_RST = 32'd1000000;

  // item actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_ARM   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_ZERO   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  // result kinds
  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // arm status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 3'd2;
  localparam logic [STAT_BITS-1:0] ST_ORDER = 3'd3;
  localparam logic [STAT_BITS-1:0] ST_EARLY = 3'd4;

  typedef struct packed {
    logic                 load_item;
    logic                 tbl_write;
    logic                 disarm;
    logic                 rd_next;
    logic                 walk_step;
    logic                 div_init;
    logic                 div_step;
    logic                 div_fix;
    logic                 cnt_prep;
    logic                 cnt_step;
    logic                 cnt_wrap;
    logic                 arm_commit;
    logic                 fire_cap;
    logic                 fire_time;
    logic                 push_report;
    logic                 push_fire;
    logic                 last;
    logic [STAT_BITS-1:0] status;
  } ptpg_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic now_early;
    logic order_bad;
    logic range_bad;
    logic walk_last;
    logic div_last;
    logic fire_ok;
    logic fire_more;
    logic out_free;
    logic armed;
    logic next_ok;
  } ptpg_stat_t;

endpackage
`default_nettype wire

// ===== sv/ptpg_in_if.sv =====
`default_nettype none
interface ptpg_in_if;
  import ptpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [TIME_BITS-1:0] time_now;
  logic [IDX_BITS-1:0]  entry_index;
  logic [DATA_BITS-1:0] entry_time;
  logic [DATA_BITS-1:0] entry_value;
  logic                 entry_stamp;

  modport source (output valid, action, time_now, entry_index, entry_time, entry_value,
                  entry_stamp, input ready);
  modport sink (input valid, action, time_now, entry_index, entry_time, entry_value,
                entry_stamp, output ready);
endinterface
`default_nettype wire

// ===== sv/ptpg_out_if.sv =====
`default_nettype none
interface ptpg_out_if;
  import ptpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [DATA_BITS-1:0] out_value;
  logic [IDX_BITS-1:0]  fired_index;
  logic                 stamp_event;
  logic [TIME_BITS-1:0] stamp_time;
  logic [STAT_BITS-1:0] status;
  logic                 last;

  modport source (output valid, kind, out_value, fired_index, stamp_event, stamp_time,
                  status, last, input ready);
  modport sink (input valid, kind, out_value, fired_index, stamp_event, stamp_time,
                status, last, output ready);
endinterface
`default_nettype wire

// ===== sv/ptpg_ctrl.sv =====
`default_nettype none
module ptpg_ctrl
  import ptpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_action,
  output logic            in_ready,
  input  wire ptpg_stat_t stat,
  output ptpg_cmd_t       cmd
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_A_START = 20'h00002,
    S_A_RD    = 20'h00004,
    S_A_CHK   = 20'h00008,
    S_D_INIT  = 20'h00010,
    S_D_RUN   = 20'h00020,
    S_D_FIX   = 20'h00040,
    S_C_PREP  = 20'h00080,
    S_C_RD    = 20'h00100,
    S_C_CHK   = 20'h00200,
    S_C_WRAP  = 20'h00400,
    S_F_RD    = 20'h00800,
    S_F_DONE  = 20'h01000,
    S_REPORT  = 20'h02000,
    S_T_START = 20'h04000,
    S_T_RD    = 20'h08000,
    S_T_CAP   = 20'h10000,
    S_T_TRD   = 20'h20000,
    S_T_TIME  = 20'h40000,
    S_T_PUSH  = 20'h80000
  } state_t;

  state_t               state_r, state_nxt;
  logic [STAT_BITS-1:0] rep_status_r, rep_status_nxt;

  // hold state and the pending report code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rep_status_r <= ST_OK;
    end else begin
      state_r      <= state_nxt;
      rep_status_r <= rep_status_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // sequence the datapath
  always_comb begin
    state_nxt      = state_r;
    rep_status_nxt = rep_status_r;
    cmd            = '0;
    cmd.status     = rep_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_action)
            ACT_WRITE: begin
              cmd.tbl_write = 1'b1;
              cmd.disarm    = 1'b1;
            end
            ACT_ARM:  state_nxt = S_A_START;
            ACT_TICK: state_nxt = S_T_START;
            default: ;
          endcase
        end
      end
      S_A_START: begin
        if (stat.n_zero) begin
          rep_status_nxt = ST_EMPTY;
          state_nxt      = S_REPORT;
        end else if (stat.now_early) begin
          rep_status_nxt = ST_EARLY;
          state_nxt      = S_REPORT;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (stat.order_bad) begin
          rep_status_nxt = ST_ORDER;
          state_nxt      = S_REPORT;
        end else if (stat.range_bad) begin
          rep_status_nxt = ST_RANGE;
          state_nxt      = S_REPORT;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt     = stat.walk_last ? S_D_INIT : S_A_RD;
        end
      end
      S_D_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_D_RUN;
      end
      S_D_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_D_FIX;
      end
      S_D_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_C_PREP;
      end
      S_C_PREP: begin
        cmd.cnt_prep = 1'b1;
        state_nxt    = S_C_RD;
      end
      S_C_RD: state_nxt = S_C_CHK;
      S_C_CHK: begin
        cmd.cnt_step = 1'b1;
        state_nxt    = stat.walk_last ? S_C_WRAP : S_C_RD;
      end
      S_C_WRAP: begin
        cmd.cnt_wrap = 1'b1;
        state_nxt    = S_F_RD;
      end
      S_F_RD: state_nxt = S_F_DONE;
      S_F_DONE: begin
        cmd.arm_commit = 1'b1;
        rep_status_nxt = ST_OK;
        state_nxt      = S_REPORT;
      end
      S_REPORT: begin
        if (stat.out_free) begin
          cmd.push_report = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_T_START: state_nxt = stat.fire_ok ? S_T_RD : S_IDLE;
      S_T_RD: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_T_CAP;
      end
      S_T_CAP: begin
        cmd.fire_cap = 1'b1;
        state_nxt    = S_T_TRD;
      end
      S_T_TRD: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_T_TIME;
      end
      S_T_TIME: begin
        cmd.fire_time = 1'b1;
        state_nxt     = S_T_PUSH;
      end
      S_T_PUSH: begin
        if (stat.out_free) begin
          cmd.push_fire = 1'b1;
          cmd.last      = !stat.fire_more;
          state_nxt     = stat.fire_more ? S_T_RD : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ptpg_dp.sv =====
`default_nettype none
module ptpg_dp
  import ptpg_pkg::*;
#(
  parameter int unsigned MAX_FIRES_PER_TICK = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ptpg_cmd_t            cmd,
  output ptpg_stat_t                stat,
  input  wire logic [TIME_BITS-1:0] in_time_now,
  input  wire logic [IDX_BITS-1:0]  in_entry_index,
  input  wire logic [DATA_BITS-1:0] in_entry_time,
  input  wire logic [DATA_BITS-1:0] in_entry_value,
  input  wire logic                 in_entry_stamp,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [DATA_BITS-1:0] cfg_wdata,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_kind,
  output logic [DATA_BITS-1:0]      out_value,
  output logic [IDX_BITS-1:0]       out_fired_index,
  output logic                      out_stamp_event,
  output logic [TIME_BITS-1:0]      out_stamp_time,
  output logic [STAT_BITS-1:0]      out_status,
  output logic                      out_last
);

  localparam int unsigned FC_BITS = $clog2(MAX_FIRES_PER_TICK + 1);

  logic [DATA_BITS-1:0]    period_r, zero_off_r;
  logic [CNT_BITS-1:0]     count_r, n_used;
  logic                    cfg_hit;

  logic [DATA_BITS-1:0]    tbl_time_r  [MAX_ENTRIES];
  logic [DATA_BITS-1:0]    tbl_value_r [MAX_ENTRIES];
  logic                    tbl_stamp_r [MAX_ENTRIES];
  logic [IDX_BITS-1:0]     rd_addr;
  logic [DATA_BITS-1:0]    rd_time_r, rd_value_r;
  logic                    rd_stamp_r;

  logic [TIME_BITS-1:0]    now_r, ext_period, ext_rem;
  logic [CNT_BITS-1:0]     idx_r, first_r;
  logic [DATA_BITS-1:0]    prev_r;
  logic [TIME_BITS-1:0]    dvd_r;
  logic [DATA_BITS-1:0]    rem_r;
  logic [DATA_BITS:0]      rem_sh, rem_sub;
  logic [DIV_CNT_BITS-1:0] bit_cnt_r;
  logic                    round_up;
  logic [TIME_BITS-1:0]    start_r, off_r;
  logic                    ahead_r;

  logic                    armed_r;
  logic [IDX_BITS-1:0]     next_index_r;
  logic [TIME_BITS-1:0]    period_start_r, next_time_r;
  logic [FC_BITS-1:0]      fire_cnt_r;
  logic [DATA_BITS-1:0]    pend_value_r;
  logic [IDX_BITS-1:0]     pend_index_r;
  logic                    pend_stamp_r;
  logic                    due;

  assign n_used     = (count_r > CNT_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES) : count_r;
  assign cfg_hit    = cfg_we && (cfg_index == REG_PERIOD || cfg_index == REG_ZERO ||
                                 cfg_index == REG_COUNT);
  assign ext_period = TIME_BITS'(period_r);
  assign ext_rem    = TIME_BITS'(rem_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RST;
      zero_off_r <= '0;
      count_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: period_r   <= cfg_wdata;
        REG_ZERO:   zero_off_r <= cfg_wdata;
        REG_COUNT:  count_r    <= cfg_wdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // transition table, one write and one registered read port
  assign rd_addr = cmd.rd_next ? next_index_r : idx_r[IDX_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tbl_write) begin
      tbl_time_r[in_entry_index]  <= in_entry_time;
      tbl_value_r[in_entry_index] <= in_entry_value;
      tbl_stamp_r[in_entry_index] <= in_entry_stamp;
    end
    rd_time_r  <= tbl_time_r[rd_addr];
    rd_value_r <= tbl_value_r[rd_addr];
    rd_stamp_r <= tbl_stamp_r[rd_addr];
  end

  // restoring divider step, one quotient bit a cycle
  assign rem_sh  = {rem_r, dvd_r[TIME_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, period_r};
  assign round_up = (rem_r >= (period_r - rem_r));

  // item time, walk counter and arm scratch
  always_ff @(posedge clk) begin
    if (cmd.load_item) now_r <= in_time_now;
    if (cmd.walk_step) prev_r <= rd_time_r;

    if (cmd.load_item || cmd.cnt_prep) begin
      idx_r <= '0;
    end else if (cmd.walk_step || cmd.cnt_step) begin
      idx_r <= idx_r + CNT_BITS'(1);
    end else if (cmd.cnt_wrap) begin
      idx_r <= (first_r == n_used) ? '0 : first_r;
    end

    if (cmd.div_init) begin
      dvd_r     <= now_r - TIME_BITS'(zero_off_r);
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= {dvd_r[TIME_BITS-2:0], 1'b0};
      rem_r     <= (rem_sh >= {1'b0, period_r}) ? rem_sub[DATA_BITS-1:0]
                                                 : rem_sh[DATA_BITS-1:0];
      bit_cnt_r <= bit_cnt_r + DIV_CNT_BITS'(1);
    end

    if (cmd.div_fix) begin
      start_r <= now_r - ext_rem + (round_up ? ext_period : '0);
    end else if (cmd.cnt_wrap && first_r == n_used) begin
      start_r <= start_r + ext_period;
    end

    if (cmd.cnt_prep) begin
      ahead_r <= (start_r > now_r);
      off_r   <= (start_r > now_r) ? '0 : now_r - start_r;
      first_r <= '0;
    end else if (cmd.cnt_step && !ahead_r && TIME_BITS'(rd_time_r) < off_r) begin
      first_r <= first_r + CNT_BITS'(1);
    end

    if (cmd.fire_cap) begin
      pend_value_r <= rd_value_r;
      pend_stamp_r <= rd_stamp_r;
      pend_index_r <= next_index_r;
    end
  end

  // playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r        <= 1'b0;
      next_index_r   <= '0;
      period_start_r <= '0;
      next_time_r    <= '0;
      fire_cnt_r     <= '0;
    end else begin
      if (cmd.disarm || cfg_hit) begin
        armed_r <= 1'b0;
      end else if (cmd.arm_commit) begin
        armed_r <= 1'b1;
      end

      if (cmd.load_item) begin
        fire_cnt_r <= '0;
      end else if (cmd.fire_cap) begin
        fire_cnt_r <= fire_cnt_r + FC_BITS'(1);
      end

      if (cmd.arm_commit) begin
        next_index_r   <= idx_r[IDX_BITS-1:0];
        period_start_r <= start_r;
        next_time_r    <= start_r + TIME_BITS'(rd_time_r);
      end else if (cmd.fire_cap) begin
        if ({1'b0, next_index_r} + CNT_BITS'(1) >= n_used) begin
          next_index_r   <= '0;
          period_start_r <= period_start_r + ext_period;
        end else begin
          next_index_r <= next_index_r + IDX_BITS'(1);
        end
      end else if (cmd.fire_time) begin
        next_time_r <= period_start_r + TIME_BITS'(rd_time_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.push_report || cmd.push_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_report) begin
      out_kind        <= KIND_REPORT;
      out_value       <= '0;
      out_fired_index <= '0;
      out_stamp_event <= 1'b0;
      out_stamp_time  <= '0;
      out_status      <= cmd.status;
      out_last        <= 1'b1;
    end else if (cmd.push_fire) begin
      out_kind        <= KIND_FIRE;
      out_value       <= pend_value_r;
      out_fired_index <= pend_index_r;
      out_stamp_event <= pend_stamp_r;
      out_stamp_time  <= now_r;
      out_status      <= ST_OK;
      out_last        <= cmd.last;
    end
  end

  // status to the controller
  assign due = (now_r >= next_time_r);

  always_comb begin
    stat.n_zero    = (n_used == '0);
    stat.now_early = (now_r < TIME_BITS'(zero_off_r));
    stat.order_bad = (idx_r != '0) && (prev_r >= rd_time_r);
    stat.range_bad = (rd_time_r >= period_r);
    stat.walk_last = ((idx_r + CNT_BITS'(1)) == n_used);
    stat.div_last  = (bit_cnt_r == DIV_CNT_BITS'(TIME_BITS - 1));
    stat.next_ok   = ({1'b0, next_index_r} < n_used);
    stat.armed     = armed_r;
    stat.fire_ok   = armed_r && (n_used != '0) && stat.next_ok && due;
    stat.fire_more = (fire_cnt_r < FC_BITS'(MAX_FIRES_PER_TICK)) && due;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== sv/periodic_transition_pattern_generator_unit.sv =====
// Periodic transition pattern generator.
// Input channel in_ch carries tick, table-write and arm items; result channel
// out_ch carries fired transitions and arm status reports; cfg_* writes the
// period, zero offset and entry count registers (a write disarms the block).
// A write item gives no result. A tick item fires at most MAX_FIRES_PER_TICK
// transitions; the last result of the tick has last set. An arm item walks
// the table, runs a bit-serial remainder unit, walks the table again and
// reports, and reports early when a check fails. The table memory has a
// single read port; one item is handled at a time. The result register
// lets a new item enter while a finished result waits; when the receiver
// stalls, the block holds in its emit step until the register drains.
// Reset disarms, loads the register defaults and empties the result
// register; table contents stay undefined until written.
`default_nettype none
`include "periodic_transition_pattern_generator_unit_defines.svh"
module periodic_transition_pattern_generator_unit
  import ptpg_pkg::*;
#(
  parameter int unsigned MAX_FIRES_PER_TICK = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ptpg_in_if.sink                   in_ch,
  ptpg_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [DATA_BITS-1:0] cfg_wdata
);

  ptpg_cmd_t  cmd;
  ptpg_stat_t stat;

  // sequencer
  ptpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table, divider and playback state
  ptpg_dp #(
    .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_time_now     (in_ch.time_now),
    .in_entry_index  (in_ch.entry_index),
    .in_entry_time   (in_ch.entry_time),
    .in_entry_value  (in_ch.entry_value),
    .in_entry_stamp  (in_ch.entry_stamp),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_value       (out_ch.out_value),
    .out_fired_index (out_ch.fired_index),
    .out_stamp_event (out_ch.stamp_event),
    .out_stamp_time  (out_ch.stamp_time),
    .out_status      (out_ch.status),
    .out_last        (out_ch.last)
  );

  // checks
  `PTPG_ASSERT_NEXT(a_cfg_disarms, cfg_we && (cfg_index == REG_PERIOD || cfg_index == REG_ZERO || cfg_index == REG_COUNT), !stat.armed, "register write left block armed")
  `PTPG_ASSERT_NOW(a_armed_index, stat.armed, stat.next_ok, "armed with pending entry beyond table")
  `PTPG_ASSERT_NOW(a_report_last, out_ch.valid && out_ch.kind == KIND_REPORT, out_ch.last, "arm report without last")
  `PTPG_ASSERT_NOW(a_fire_status, out_ch.valid && out_ch.kind == KIND_FIRE, out_ch.status == ST_OK, "fired transition with status")

endmodule
`default_nettype wire
